>>> hw/rtl/rwlt_pkg.sv
// ----------------------------------------------------------------------------
// rwlt_pkg
// Shared types and constants for the recency window LRU tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package rwlt_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;

  localparam int KEY_W   = 64;
  localparam int TURN_W  = 32;
  localparam int TOTAL_W = 32;
  localparam int WIN_W   = 16;

  // window used when the register holds zero
  localparam logic [WIN_W-1:0] DEFAULT_WINDOW = 16'd3;

  // APB register map: one 32-bit register per word
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_WINDOW_TURNS = 1'b0;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [TURN_W-1:0] turn;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_RESULT
  } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/rwlt_if.sv
// ----------------------------------------------------------------------------
// rwlt_if
// Valid/ready channels for observations in and tracker results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface rwlt_in_if
  import rwlt_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [KEY_W-1:0]  key;
  logic [TURN_W-1:0] turn;

  modport source (output valid, output key, output turn, input ready);
  modport sink   (input valid, input key, input turn, output ready);
endinterface

interface rwlt_out_if
  import rwlt_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic               trigger;
  logic               hit;
  logic [TOTAL_W-1:0] trigger_total;

  modport source (output valid, output trigger, output hit, output trigger_total,
                  input ready);
  modport sink   (input valid, input trigger, input hit, input trigger_total,
                  output ready);
endinterface

`default_nettype wire

>>> hw/rtl/recency_window_lru_tracker.sv
// ----------------------------------------------------------------------------
// recency_window_lru_tracker
// Small associative table of keys with last-seen turns; flags repeats.
//
// Each transfer on in_ch brings a 64-bit key and a 32-bit turn. The block
// looks the key up in a table of TABLE_ENTRIES slots held in one RAM, walking
// the filled slots one per cycle through a single key compare and a single
// turn compare, which also tracks the least recently seen slot (lowest index
// on ties). A hit raises trigger when the turn is later than the stored one
// by no more than the window (register window_turns, 0 selects the default of
// 3), and moves the stored turn forward only. A miss fills the next free slot
// or, once the table is full, replaces the least recent one. Key 0 changes
// nothing. Every observation gives exactly one result: trigger, hit and the
// saturating trigger count. A miss reads every filled slot in the scan;
// a hit ends the scan early at the matching slot. The scan is followed by
// the table update and the loading of the result register, after which the
// block returns to idle; key 0 skips the scan and the update. The RAM read
// port, one slot per cycle, sets the length of the scan. The block takes
// one item at a time; a finished result sits in the output register, so
// the next item can be taken while the result waits. Slots are never
// cleared: only filled slots are read, so no clearing pass is needed after
// reset.
// ----------------------------------------------------------------------------
`default_nettype none

module recency_window_lru_tracker
  import rwlt_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,

  rwlt_in_if.sink                    in_ch,
  rwlt_out_if.source                 out_ch,

  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output      logic [CFG_DATA_W-1:0] prdata,
  output      logic                  pready
);

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int USED_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [USED_W-1:0] ENTRIES_MAX = USED_W'(TABLE_ENTRIES);

  // sequencer
  state_t state_r, state_nxt;

  // current item
  logic [KEY_W-1:0]  key_r;
  logic [TURN_W-1:0] turn_r;

  // configuration
  logic [WIN_W-1:0] win_r;
  logic [WIN_W-1:0] win_eff;

  // table bookkeeping
  logic [USED_W-1:0]  used_r;
  logic [TOTAL_W-1:0] count_r;

  // scan state: rd_idx_r is the next slot to read, cmp_* the slot whose
  // data is on the RAM output this cycle
  logic [USED_W-1:0] rd_idx_r;
  logic              cmp_vld_r;
  logic [IDX_W-1:0]  cmp_idx_r;
  logic              hit_r;
  logic [IDX_W-1:0]  hit_idx_r;
  logic [TURN_W-1:0] prev_r;
  logic              best_vld_r;
  logic [IDX_W-1:0]  best_idx_r;
  logic [TURN_W-1:0] best_turn_r;

  // result register
  logic               out_valid_r;
  logic               out_trigger_r;
  logic               out_hit_r;
  logic [TOTAL_W-1:0] out_total_r;

  // RAM port
  entry_t           rd_ent;
  entry_t           wr_ent;
  logic             ram_we;
  logic             ram_re;
  logic [IDX_W-1:0] ram_waddr;

  // control
  logic              in_xfer;
  logic              match;
  logic              older;
  logic              scan_done;
  logic              later;
  logic [TURN_W-1:0] gap;
  logic              trig_now;
  logic              out_load;
  logic              cfg_wr;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite &&
                  (paddr[CFG_ADDR_W-1] == REG_WINDOW_TURNS);

  always_comb begin
    prdata = '0;
    if (paddr[CFG_ADDR_W-1] == REG_WINDOW_TURNS) begin
      prdata = CFG_DATA_W'(win_r);
    end
  end

  assign win_eff = (win_r == '0) ? DEFAULT_WINDOW : win_r;

  // --------------------------------------------------------------------------
  // Table RAM
  // --------------------------------------------------------------------------
  rwlt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (wr_ent),
    .re      (ram_re),
    .raddr   (rd_idx_r[IDX_W-1:0]),
    .rdata_r (rd_ent)
  );

  assign wr_ent.key  = key_r;
  assign wr_ent.turn = turn_r;

  // --------------------------------------------------------------------------
  // Shared compare unit: one key compare and one turn compare per cycle
  // --------------------------------------------------------------------------
  assign match = cmp_vld_r && (rd_ent.key == key_r);
  assign older = cmp_vld_r && !match &&
                 (!best_vld_r || (rd_ent.turn < best_turn_r));

  // update math on a hit
  assign later    = turn_r > prev_r;
  assign gap      = turn_r - prev_r;
  assign trig_now = hit_r && later && (gap <= TURN_W'(win_eff));

  // --------------------------------------------------------------------------
  // Sequencer outputs
  // --------------------------------------------------------------------------
  always_comb begin
    in_ch.ready = 1'b0;
    ram_re      = 1'b0;
    ram_we      = 1'b0;
    scan_done   = 1'b0;
    out_load    = 1'b0;
    ram_waddr   = hit_idx_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
      end
      ST_SCAN: begin
        ram_re    = !match && (rd_idx_r < used_r);
        scan_done = match || (!cmp_vld_r && (rd_idx_r >= used_r));
      end
      ST_UPDATE: begin
        if (hit_r) begin
          ram_we    = later;
          ram_waddr = hit_idx_r;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = (used_r < ENTRIES_MAX) ? used_r[IDX_W-1:0] : best_idx_r;
        end
      end
      ST_RESULT: begin
        out_load = !out_valid_r || out_ch.ready;
      end
      default: begin
        in_ch.ready = 1'b0;
      end
    endcase
  end

  assign in_xfer = in_ch.valid && in_ch.ready;

  // --------------------------------------------------------------------------
  // Sequencer next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          // empty key skips the table altogether
          state_nxt = (in_ch.key == '0) ? ST_RESULT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      win_r       <= '0;
      used_r      <= '0;
      count_r     <= '0;
      rd_idx_r    <= '0;
      cmp_vld_r   <= 1'b0;
      hit_r       <= 1'b0;
      best_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_wr) begin
        win_r <= pwdata[WIN_W-1:0];
      end

      if (in_xfer) begin
        rd_idx_r   <= '0;
        cmp_vld_r  <= 1'b0;
        hit_r      <= 1'b0;
        best_vld_r <= 1'b0;
      end

      if (state_r == ST_SCAN) begin
        cmp_vld_r <= ram_re;
        if (ram_re) begin
          rd_idx_r <= rd_idx_r + 1'b1;
        end
        if (match) begin
          hit_r <= 1'b1;
        end
        if (older) begin
          best_vld_r <= 1'b1;
        end
      end

      if (state_r == ST_UPDATE) begin
        if (!hit_r && (used_r < ENTRIES_MAX)) begin
          used_r <= used_r + 1'b1;
        end
        // count saturates at all ones
        if (trig_now && (count_r != '1)) begin
          count_r <= count_r + 1'b1;
        end
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      key_r  <= in_ch.key;
      turn_r <= in_ch.turn;
    end

    if (state_r == ST_SCAN) begin
      if (ram_re) begin
        cmp_idx_r <= rd_idx_r[IDX_W-1:0];
      end
      if (match) begin
        hit_idx_r <= cmp_idx_r;
        prev_r    <= rd_ent.turn;
      end
      if (older) begin
        best_idx_r  <= cmp_idx_r;
        best_turn_r <= rd_ent.turn;
      end
    end

    if (out_load) begin
      out_trigger_r <= (key_r != '0) && trig_now;
      out_hit_r     <= (key_r != '0) && hit_r;
      out_total_r   <= count_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.trigger       = out_trigger_r;
  assign out_ch.hit           = out_hit_r;
  assign out_ch.trigger_total = out_total_r;

endmodule

`default_nettype wire

>>> hw/rtl/rwlt_ram.sv
// ----------------------------------------------------------------------------
// rwlt_ram
// Generic simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module rwlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire
